/* hdl/dpf_pkg.sv */
`default_nettype none

package dpf_pkg;

	localparam int NUM_SEGMENTS = 8;
	localparam int SEG_IDX_W    = $clog2(NUM_SEGMENTS);
	localparam int SEG_CNT_W    = 4;
	localparam int HIT_W        = 3;
	localparam int ADDR_W       = 32;
	localparam int PAGE_BYTES   = 4096;
	localparam int BYTES_W      = 13;
	localparam int FRAG_W       = 44;
	localparam int CNT_W        = 32;

	localparam logic [ADDR_W-1:0] PAGE_MASK = ~ADDR_W'(PAGE_BYTES - 1);

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_FAULT = 1'b1;

	typedef struct packed {
		logic              func;
		logic [2:0]        entry_index;
		logic              entry_loadable;
		logic [ADDR_W-1:0] entry_start;
		logic [ADDR_W-1:0] entry_mem_size;
		logic [ADDR_W-1:0] entry_file_size;
		logic [ADDR_W-1:0] entry_file_offset;
		logic [ADDR_W-1:0] fault_address;
	} req_t;

	typedef struct packed {
		logic               segment_found;
		logic [HIT_W-1:0]   hit_index;
		logic [ADDR_W-1:0]  page_base;
		logic [ADDR_W-1:0]  source_offset;
		logic [BYTES_W-1:0] copy_bytes;
		logic [BYTES_W-1:0] useful_bytes;
		logic [CNT_W-1:0]   fault_total;
		logic [CNT_W-1:0]   pages_total;
		logic [FRAG_W-1:0]  fragmentation_bytes;
	} rsp_t;

	// table write broadcast to every cell
	typedef struct packed {
		logic              en;
		logic [2:0]        index;
		logic              loadable;
		logic [ADDR_W-1:0] start;
		logic [ADDR_W-1:0] mem_size;
		logic [ADDR_W-1:0] file_size;
		logic [ADDR_W-1:0] file_offset;
	} wr_t;

	// search token passed cell to cell
	typedef struct packed {
		logic                 valid;
		logic                 found;
		logic [SEG_IDX_W-1:0] hit;
		logic [ADDR_W-1:0]    addr;
		logic [ADDR_W-1:0]    start;
		logic [ADDR_W-1:0]    mem_size;
		logic [ADDR_W-1:0]    file_size;
		logic [ADDR_W-1:0]    file_offset;
	} token_t;

endpackage

`default_nettype wire

/* hdl/dpf_if.sv */
`default_nettype none

interface dpf_req_if;
	logic          valid;
	logic          ready;
	dpf_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dpf_rsp_if;
	logic          valid;
	logic          ready;
	dpf_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/dpf_cell.sv */
`default_nettype none

module dpf_cell (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [dpf_pkg::SEG_IDX_W-1:0] cell_index,
	input  wire logic [dpf_pkg::SEG_CNT_W-1:0] seg_limit,
	input  wire dpf_pkg::wr_t                  wr,
	input  wire dpf_pkg::token_t               tok_in,
	output dpf_pkg::token_t                    tok_out
);

	logic                        loadable_q;
	logic [dpf_pkg::ADDR_W-1:0]  start_q;
	logic [dpf_pkg::ADDR_W-1:0]  mem_size_q;
	logic [dpf_pkg::ADDR_W-1:0]  file_size_q;
	logic [dpf_pkg::ADDR_W-1:0]  file_offset_q;
	logic [dpf_pkg::ADDR_W:0]    end_addr;
	logic                        in_range;
	logic                        match;
	dpf_pkg::token_t             tok_next;
	dpf_pkg::token_t             tok_q;

	always_ff @(posedge clk) begin
		if (wr.en && (32'(wr.index) == 32'(cell_index))) begin
			loadable_q    <= wr.loadable;
			start_q       <= wr.start;
			mem_size_q    <= wr.mem_size;
			file_size_q   <= wr.file_size;
			file_offset_q <= wr.file_offset;
		end
	end

	always_comb begin
		end_addr = {1'b0, start_q} + {1'b0, mem_size_q};
		in_range = (32'(cell_index) < 32'(seg_limit));
		match    = tok_in.valid && !tok_in.found && in_range && loadable_q &&
		           (tok_in.addr >= start_q) && ({1'b0, tok_in.addr} < end_addr);
		tok_next = tok_in;
		if (match) begin
			tok_next.found       = 1'b1;
			tok_next.hit         = cell_index;
			tok_next.start       = start_q;
			tok_next.mem_size    = mem_size_q;
			tok_next.file_size   = file_size_q;
			tok_next.file_offset = file_offset_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_next;
		end
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire

/* hdl/demand_page_fault_resolver.sv */
// Channel  Dir  Payload                      Transfer
// req      in   func, entry fields, address  valid & ready
// rsp      out  lookup result and counters   valid & ready
// cfg      in   segment_count                cfg_we
//
// A table write updates its cell on transfer; the next item is taken right after.
// A fault walks the eight-cell chain one cell per cycle, then the clip,
// count and emit steps; the next item is taken only once emit raises
// the result, later if rsp is stalled.
// Reset clears the counters and segment_count; table entries hold garbage
// until written.
`default_nettype none

module demand_page_fault_resolver (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	dpf_req_if.sink                            req,
	dpf_rsp_if.source                          rsp,
	input  wire logic                          cfg_we,
	input  wire logic [dpf_pkg::SEG_CNT_W-1:0] cfg_wdata
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_CLIP,
		S_COUNT,
		S_EMIT
	} state_t;

	state_t                          state_q;
	logic [dpf_pkg::SEG_CNT_W-1:0]   seg_count_q;
	dpf_pkg::wr_t                    wr;
	dpf_pkg::token_t                 tok [dpf_pkg::NUM_SEGMENTS+1];
	dpf_pkg::token_t                 tail;

	logic                            found_s1;
	logic [dpf_pkg::SEG_IDX_W-1:0]   hit_s1;
	logic [dpf_pkg::ADDR_W-1:0]      pb_s1;
	logic [dpf_pkg::ADDR_W:0]        start_s1;
	logic [dpf_pkg::ADDR_W:0]        end_s1;
	logic [dpf_pkg::ADDR_W:0]        pend_s1;
	logic [dpf_pkg::ADDR_W:0]        off_s1;
	logic [dpf_pkg::ADDR_W-1:0]      fsize_s1;
	logic [dpf_pkg::ADDR_W-1:0]      foff_s1;

	logic [dpf_pkg::ADDR_W-1:0]      src_s2;
	logic [dpf_pkg::BYTES_W-1:0]     copy_s2;
	logic [dpf_pkg::BYTES_W-1:0]     useful_s2;

	logic [dpf_pkg::CNT_W-1:0]       fault_q;
	logic [dpf_pkg::CNT_W-1:0]       pages_q;
	logic [dpf_pkg::FRAG_W-1:0]      mapped_q;

	logic                            rsp_valid_q;
	dpf_pkg::rsp_t                   rsp_q;

	logic [dpf_pkg::ADDR_W:0]        lo;
	logic [dpf_pkg::ADDR_W:0]        hi;
	logic [dpf_pkg::ADDR_W:0]        overlap;
	logic [dpf_pkg::ADDR_W-1:0]      rem;
	logic [dpf_pkg::BYTES_W-1:0]     copy_n;
	logic [dpf_pkg::FRAG_W:0]        mapped_sum;
	logic [dpf_pkg::FRAG_W-1:0]      total;
	logic [dpf_pkg::FRAG_W-1:0]      frag;
	logic                            accept;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_count_q <= '0;
		end else if (cfg_we) begin
			seg_count_q <= cfg_wdata;
		end
	end

	always_comb begin
		wr.en          = accept && (req.data.func == dpf_pkg::FUNC_WRITE);
		wr.index       = req.data.entry_index;
		wr.loadable    = req.data.entry_loadable;
		wr.start       = req.data.entry_start;
		wr.mem_size    = req.data.entry_mem_size;
		wr.file_size   = req.data.entry_file_size;
		wr.file_offset = req.data.entry_file_offset;
	end

	// token launched into the first cell on a fault transfer
	always_comb begin
		tok[0]       = '0;
		tok[0].valid = accept && (req.data.func == dpf_pkg::FUNC_FAULT);
		tok[0].addr  = req.data.fault_address;
	end

	for (genvar i = 0; i < dpf_pkg::NUM_SEGMENTS; i++) begin : g_cell
		dpf_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cell_index (dpf_pkg::SEG_IDX_W'(i)),
			.seg_limit  (seg_count_q),
			.wr         (wr),
			.tok_in     (tok[i]),
			.tok_out    (tok[i+1])
		);
	end

	assign tail = tok[dpf_pkg::NUM_SEGMENTS];

	// page geometry, latched when the token leaves the chain
	always_ff @(posedge clk) begin
		if (state_q == S_SCAN && tail.valid) begin
			found_s1 <= tail.found;
			hit_s1   <= tail.hit;
			pb_s1    <= tail.addr & dpf_pkg::PAGE_MASK;
			start_s1 <= {1'b0, tail.start};
			end_s1   <= {1'b0, tail.start} + {1'b0, tail.mem_size};
			pend_s1  <= {1'b0, tail.addr & dpf_pkg::PAGE_MASK} +
			            (dpf_pkg::ADDR_W+1)'(dpf_pkg::PAGE_BYTES);
			off_s1   <= {1'b0, tail.addr & dpf_pkg::PAGE_MASK} - {1'b0, tail.start};
			fsize_s1 <= tail.file_size;
			foff_s1  <= tail.file_offset;
		end
	end

	always_comb begin
		lo      = ({1'b0, pb_s1} > start_s1) ? {1'b0, pb_s1} : start_s1;
		hi      = (pend_s1 < end_s1) ? pend_s1 : end_s1;
		overlap = (hi > lo) ? (hi - lo) : '0;
		rem     = fsize_s1 - off_s1[dpf_pkg::ADDR_W-1:0];
		copy_n  = '0;
		// off_s1 sign bit set: page starts below the segment
		if (!off_s1[dpf_pkg::ADDR_W] && (off_s1[dpf_pkg::ADDR_W-1:0] < fsize_s1)) begin
			copy_n = (rem > dpf_pkg::ADDR_W'(dpf_pkg::PAGE_BYTES)) ?
			         dpf_pkg::BYTES_W'(dpf_pkg::PAGE_BYTES) : rem[dpf_pkg::BYTES_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CLIP) begin
			src_s2    <= found_s1 ? (foff_s1 + off_s1[dpf_pkg::ADDR_W-1:0]) : '0;
			copy_s2   <= found_s1 ? copy_n : '0;
			useful_s2 <= found_s1 ? overlap[dpf_pkg::BYTES_W-1:0] : '0;
		end
	end

	assign mapped_sum = {1'b0, mapped_q} + (dpf_pkg::FRAG_W+1)'(useful_s2);
	assign total      = dpf_pkg::FRAG_W'(pages_q) << $clog2(dpf_pkg::PAGE_BYTES);
	assign frag       = (total > mapped_q) ? (total - mapped_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fault_q     <= '0;
			pages_q     <= '0;
			mapped_q    <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_valid_q && rsp.ready && state_q != S_EMIT) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && req.data.func == dpf_pkg::FUNC_FAULT) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (tail.valid) begin
						state_q <= S_CLIP;
					end
				end
				S_CLIP: begin
					state_q <= S_COUNT;
				end
				S_COUNT: begin
					if (fault_q != '1) begin
						fault_q <= fault_q + 1'b1;
					end
					if (found_s1) begin
						if (pages_q != '1) begin
							pages_q <= pages_q + 1'b1;
						end
						mapped_q <= mapped_sum[dpf_pkg::FRAG_W] ? '1 :
						            mapped_sum[dpf_pkg::FRAG_W-1:0];
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q               <= 1'b1;
						rsp_q.segment_found       <= found_s1;
						rsp_q.hit_index           <= found_s1 ? dpf_pkg::HIT_W'(hit_s1) : '0;
						rsp_q.page_base           <= pb_s1;
						rsp_q.source_offset       <= src_s2;
						rsp_q.copy_bytes          <= copy_s2;
						rsp_q.useful_bytes        <= useful_s2;
						rsp_q.fault_total         <= fault_q;
						rsp_q.pages_total         <= pages_q;
						rsp_q.fragmentation_bytes <= frag;
						state_q                   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// a search token reaches the end of the chain only while scanning
	a_tail_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tail.valid |-> state_q == S_SCAN)
		else $error("token left the chain outside a scan");

	a_pages_le_faults: assert property (@(posedge clk) disable iff (!arst_n)
		pages_q <= fault_q)
		else $error("more pages than faults");

	a_rsp_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == S_EMIT)
		else $error("result raised outside the emit step");

	// a covering segment always overlaps its page by at least one byte
	a_hit_useful: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.segment_found) |->
		(rsp_q.useful_bytes != '0 && 32'(rsp_q.hit_index) < 32'(seg_count_q)))
		else $error("hit with no overlap or outside the searched entries");

endmodule

`default_nettype wire
